// File: src/assert_macros.svh
// Assertion macros for the duplicate window RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SDW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define SDW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/sdw_pkg.sv
// Types and constants for the sequence duplicate window
`timescale 1ns / 1ps
package sdw_pkg;
	localparam int WINDOW = 64;
	localparam int SEQ_W = 32;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int IDX_W = $clog2(WINDOW);

	typedef logic [SEQ_W-1:0] seq_t;
	typedef logic [WINDOW-1:0] bitmap_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic is_new;
		logic beyond_window;
		seq_t contiguous_base;
	} res_t;

	typedef struct packed {
		res_t res;
		bitmap_t bitmap;
	} upd_t;
endpackage

// File: src/sdw_ifs.sv
// Channel interfaces: sequence input, result output, configuration write
`timescale 1ns / 1ps
interface sdw_seq_if;
	import sdw_pkg::*;
	logic valid;
	logic ready;
	seq_t seq;
	modport source (output valid, output seq, input ready);
	modport sink (input valid, input seq, output ready);
endinterface

interface sdw_res_if;
	import sdw_pkg::*;
	logic valid;
	logic ready;
	logic is_new;
	logic beyond_window;
	seq_t contiguous_base;
	modport source (output valid, output is_new, output beyond_window,
		output contiguous_base, input ready);
	modport sink (input valid, input is_new, input beyond_window,
		input contiguous_base, output ready);
endinterface

interface sdw_cfg_if;
	import sdw_pkg::*;
	logic valid;
	logic ready;
	seq_t start_base;
	modport source (output valid, output start_base, input ready);
	modport sink (input valid, input start_base, output ready);
endinterface

// File: src/sequence_duplicate_window.sv
// Top level of the sequence number duplicate detector
//
// Usage: sequence numbers arrive on seq_ch (valid/ready); each transfer
// yields exactly one result on res_ch: is_new, beyond_window and the
// contiguous base after that number. All numbers at or below the base
// count as seen; a bitmap tracks the WINDOW numbers above it.
// A number waits in the input register, its result in the result register.
// Throughput: one number per cycle while res_ch.ready is high; the check,
// trailing-ones count and bitmap shift are combinational between the stages.
// Stall: when res_ch.ready is low the result register holds; the input
// register takes one more number only if it is empty while the result waits.
// Reset (arst_n low): base is 0, bitmap cleared, both stages empty.
// cfg_ch loads a new base and clears the bitmap; write it only while idle.
// cfg_ch.ready is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sequence_duplicate_window (
	input logic clk,
	input logic arst_n,
	sdw_seq_if.sink seq_ch,
	sdw_res_if.source res_ch,
	sdw_cfg_if.sink cfg_ch
);
	import sdw_pkg::*;

	seq_t base_q;
	bitmap_t bitmap_q;
	logic valid_s1;
	seq_t seq_s1;
	logic valid_s2;
	res_t res_s2;
	logic adv_s2;
	logic move_s1;
	logic cfg_fire;
	upd_t upd;

	sdw_check u_check (
		.seq(seq_s1),
		.base(base_q),
		.bitmap(bitmap_q),
		.upd(upd)
	);

	assign adv_s2 = !valid_s2 || res_ch.ready;
	assign move_s1 = valid_s1 && adv_s2;
	assign seq_ch.ready = !valid_s1 || adv_s2;
	assign cfg_ch.ready = 1'b1;
	assign cfg_fire = cfg_ch.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			base_q <= '0;
			bitmap_q <= '0;
		end else begin
			if (seq_ch.ready)
				valid_s1 <= seq_ch.valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (cfg_fire) begin
				base_q <= cfg_ch.start_base;
				bitmap_q <= '0;
			end else if (move_s1) begin
				base_q <= upd.res.contiguous_base;
				bitmap_q <= upd.bitmap;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_ch.valid && seq_ch.ready)
			seq_s1 <= seq_ch.seq;
		if (move_s1)
			res_s2 <= upd.res;
	end

	assign res_ch.valid = valid_s2;
	assign res_ch.is_new = res_s2.is_new;
	assign res_ch.beyond_window = res_s2.beyond_window;
	assign res_ch.contiguous_base = res_s2.contiguous_base;

	`SDW_ASSERT_NOW(a_new_xor_beyond, valid_s2, !(res_s2.is_new && res_s2.beyond_window))
	`SDW_ASSERT_NOW(a_bitmap_low_clear, 1'b1, !bitmap_q[0])
	`SDW_ASSERT_NEXT(a_base_monotonic, !cfg_fire, base_q >= $past(base_q))
	`SDW_ASSERT_NEXT(a_result_base, move_s1 && !cfg_fire, res_s2.contiguous_base == base_q)
endmodule

// File: src/sdw_check.sv
// Window lookup, mark, trailing-ones count and base advance for one number
`timescale 1ns / 1ps
module sdw_check (
	input  sdw_pkg::seq_t    seq,
	input  sdw_pkg::seq_t    base,
	input  sdw_pkg::bitmap_t bitmap,
	output sdw_pkg::upd_t    upd
);
	import sdw_pkg::*;

	seq_t diff;
	logic above;
	logic beyond;
	idx_t idx;
	logic is_new;
	bitmap_t marked;
	bitmap_t lowest_zero;
	cnt_t run;

	assign above = seq > base;
	assign diff = seq - base;
	assign beyond = above && (diff > SEQ_W'(WINDOW));
	assign idx = IDX_W'(diff - SEQ_W'(1));
	assign is_new = above && !beyond && !bitmap[idx];

	always_comb begin
		marked = bitmap;
		marked[idx] = 1'b1;
	end

	assign lowest_zero = ~marked & (marked + bitmap_t'(1));

	always_comb begin
		run = '0;
		if (&marked) begin
			run = CNT_W'(WINDOW);
		end else begin
			for (int i = 0; i < WINDOW; i++) begin
				if (lowest_zero[i])
					run = run | CNT_W'(i);
			end
		end
	end

	always_comb begin
		upd.res.is_new = is_new;
		upd.res.beyond_window = beyond;
		if (is_new) begin
			upd.res.contiguous_base = base + SEQ_W'(run);
			upd.bitmap = marked >> run;
		end else begin
			upd.res.contiguous_base = base;
			upd.bitmap = bitmap;
		end
	end
endmodule

// File: tb/testbench.sv
// Testbench for sequence_duplicate_window: directed and random sequence numbers
`timescale 1ns / 1ps
module testbench;
	import sdw_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned SEGMENT_ITEMS = 110;

	logic clk;
	logic arst_n;

	sdw_seq_if seq_ch();
	sdw_res_if res_ch();
	sdw_cfg_if cfg_ch();

	sequence_duplicate_window dut (
		.clk(clk),
		.arst_n(arst_n),
		.seq_ch(seq_ch),
		.res_ch(res_ch),
		.cfg_ch(cfg_ch)
	);

	seq_t window_base;
	bitmap_t seen_map;
	res_t pending_results[$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_t mark_seq(seq_t s);
		res_t r;
		seq_t gap;
		bitmap_t bit_m;
		int unsigned run;
		r = '0;
		if (s > window_base) begin
			gap = s - window_base;
			if (gap > seq_t'(WINDOW)) begin
				r.beyond_window = 1'b1;
			end else begin
				bit_m = bitmap_t'(1) << (gap - 1);
				if ((seen_map & bit_m) == '0) begin
					r.is_new = 1'b1;
					seen_map = seen_map | bit_m;
					run = 0;
					while (run < WINDOW && seen_map[run])
						run++;
					window_base = window_base + seq_t'(run);
					if (run >= WINDOW)
						seen_map = '0;
					else
						seen_map = seen_map >> run;
				end
			end
		end
		r.contiguous_base = window_base;
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic send_seq(input seq_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			seq_ch.valid <= 1'b0;
			@(posedge clk);
		end
		seq_ch.valid <= 1'b1;
		seq_ch.seq <= s;
		do @(posedge clk); while (!seq_ch.ready);
		pending_results.insert(pending_results.size(), mark_seq(s));
	endtask

	task automatic load_start_base(input seq_t v);
		seq_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.start_base <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		window_base = v;
		seen_map = '0;
	endtask

	// shuffled fill of the numbers just above the base, sometimes closing with base+1
	task automatic send_fill_block(input int unsigned k);
		seq_t blk[WINDOW];
		seq_t tmp;
		int unsigned j;
		for (int unsigned i = 0; i < k; i++)
			blk[i] = window_base + seq_t'(i + 1);
		for (int unsigned i = k - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			tmp = blk[i];
			blk[i] = blk[j];
			blk[j] = tmp;
		end
		if ($urandom_range(2) == 0) begin
			for (int unsigned i = 0; i < k; i++) begin
				if (blk[i] == window_base + 1) begin
					blk[i] = blk[k - 1];
					blk[k - 1] = window_base + 1;
				end
			end
		end
		for (int unsigned i = 0; i < k; i++)
			send_seq(blk[i]);
	endtask

	task automatic run_traffic(input int unsigned n);
		int unsigned sent;
		int unsigned pick;
		int unsigned k;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				k = $urandom_range(WINDOW, 1);
				send_fill_block(k);
				sent += k;
			end else begin
				if (pick < 55)
					send_seq(window_base + 1 + $urandom_range(WINDOW - 1, 0));
				else if (pick < 68)
					send_seq(window_base - $urandom_range(3, 0));
				else if (pick < 78)
					send_seq(window_base + WINDOW + $urandom_range(1, 0));
				else if (pick < 88)
					send_seq(window_base + WINDOW + 1 + $urandom_range(5000, 0));
				else
					send_seq($urandom);
				sent++;
			end
		end
	endtask

	task automatic check_reset_window();
		send_seq(32'd0);
		send_seq(32'd1);
		send_seq(32'd3);
		send_seq(32'd3);
		send_seq(32'd2);
		send_seq(32'd67);
		send_seq(32'd68);
		send_seq(32'hFFFF_FFFF);
	endtask

	task automatic check_top_of_range();
		load_start_base(32'hFFFF_FFC0);
		send_seq(32'hFFFF_FFFF);
		send_seq(32'hFFFF_FFC1);
		send_seq(32'd0);
		send_seq(32'hFFFF_FFFF);
		load_start_base(32'hFFFF_FFFF);
		send_seq(32'hFFFF_FFFF);
		send_seq(32'd0);
		load_start_base(32'hFFFF_FFFE);
		send_seq(32'hFFFF_FFFF);
		load_start_base(32'd0);
		send_seq(32'hFFFF_FFFF);
		send_seq(32'd64);
	endtask

	task automatic run_random_phase(input int unsigned s_idle, input int unsigned r_idle);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		load_start_base($urandom);
		run_traffic(SEGMENT_ITEMS);
		load_start_base(32'hFFFF_FFFF - $urandom_range(200, 0));
		run_traffic(SEGMENT_ITEMS);
		load_start_base($urandom_range(100, 0));
		run_traffic(SEGMENT_ITEMS);
		load_start_base($urandom);
		run_traffic(SEGMENT_ITEMS);
	endtask

	always @(posedge clk) begin
		res_t want;
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result transfer with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (res_ch.is_new !== want.is_new)
					flag_mismatch($sformatf("is_new %b, want %b",
						res_ch.is_new, want.is_new));
				if (res_ch.beyond_window !== want.beyond_window)
					flag_mismatch($sformatf("beyond_window %b, want %b",
						res_ch.beyond_window, want.beyond_window));
				if (res_ch.contiguous_base !== want.contiguous_base)
					flag_mismatch($sformatf("contiguous_base %h, want %h",
						res_ch.contiguous_base, want.contiguous_base));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		mismatch_count = 0;
		send_idle_pct = 26;
		recv_idle_pct = 51;
		window_base = '0;
		seen_map = '0;
		arst_n = 1'b0;
		seq_ch.valid = 1'b0;
		seq_ch.seq = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.start_base = '0;
		res_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_window();
		check_top_of_range();
		run_random_phase(26, 51);
		run_random_phase(51, 26);
		run_random_phase(0, 0);

		seq_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
